/* hw/rtl/hkv_pkg.sv */
// Shared types, codes and the key mixing step of the hashed key-value table.
`timescale 1ns / 1ps

package hkv_pkg;

  localparam int unsigned KEY_W              = 32;
  localparam int unsigned VALUE_W            = 32;
  localparam int unsigned CFG_W              = 9;
  localparam int unsigned BUCKETS_DEFAULT    = 256;
  localparam int unsigned WAYS_DEFAULT       = 4;
  localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 9'd256;

  // The key mix runs as a fixed sequence of add or xor-shift steps.
  localparam int unsigned HASH_STEPS = 6;
  localparam int unsigned STEP_W     = 3;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] new_value;
  } hkv_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] read_value;
  } hkv_rsp_t;

  function automatic logic [KEY_W-1:0] hkv_mix_step(input logic [KEY_W-1:0] k,
                                                    input logic [STEP_W-1:0] step);
    logic [KEY_W-1:0] r;
    begin
      case (step)
        3'd0:    r = (~k) + (k << 15);
        3'd1:    r = k ^ (k >> 12);
        3'd2:    r = k + (k << 2);
        3'd3:    r = k ^ (k >> 4);
        3'd4:    r = k + ((k << 3) + (k << 11));
        3'd5:    r = k ^ (k >> 16);
        default: r = k;
      endcase
      return r;
    end
  endfunction

endpackage

/* hw/rtl/hashed_key_value_table.sv */
// Top level of the hashed key-value table: sequencer, entry memories, ports.
//
// Requests arrive on the in channel (in_valid_i / in_ready_o, payload
// in_data_i) as insert, delete or get of a 32-bit key. Every request gives
// exactly one response on the out channel (out_valid_o / out_ready_i,
// payload out_data_o) with a status and, for a get that hits, the value.
// The cfg channel writes the bucket count; cfg_ready_o is always high, and
// it must only be written while no request is in flight.
// A request goes from transfer to response through the shared hash and
// remainder unit (six mix steps and a 32-step restoring division, plus its
// registered done flag), a valid-row read, a scan that pipelines one
// key/value read per way, and an update state. One request is in flight at
// a time; in_ready_o is high only while the sequencer is idle.
// After reset the valid rows are cleared one bucket per cycle, so in_ready_o
// stays low until every row is cleared. The response sits in an output
// register, so a new request is taken while it waits; if the receiver still
// stalls when the next response is ready, the sequencer holds in its update
// state until the output register is free.
`timescale 1ns / 1ps

module hashed_key_value_table #(
  parameter int unsigned BUCKETS = hkv_pkg::BUCKETS_DEFAULT,
  parameter int unsigned WAYS    = hkv_pkg::WAYS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [hkv_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  hkv_pkg::hkv_req_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output hkv_pkg::hkv_rsp_t         out_data_o
);

  import hkv_pkg::*;

  localparam int unsigned SLOTS = BUCKETS * WAYS;
  localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned DW    = $clog2(BUCKETS + 1);
  localparam int unsigned WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CW    = $clog2(WAYS + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_VRD   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_ACT   = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CFG_W-1:0]   bucket_count_q;
  logic [DW-1:0]      active_count;
  hkv_req_t           req_q, req_d;
  logic [BW-1:0]      bucket_q, bucket_d;
  logic [AW-1:0]      base_q, base_d;
  logic [BW-1:0]      clr_q, clr_d;
  logic [CW-1:0]      wc_q, wc_d;
  logic               pend_q, pend_d;
  logic [WW-1:0]      pw_q, pw_d;
  logic               hit_q, hit_d;
  logic [WW-1:0]      hit_way_q, hit_way_d;
  logic [VALUE_W-1:0] hit_val_q, hit_val_d;
  logic               free_q, free_d;
  logic [WW-1:0]      free_way_q, free_way_d;
  logic               out_valid_q, out_valid_d;
  hkv_rsp_t           out_data_q, out_data_d;

  logic               unit_start;
  logic               unit_done;
  logic [BW-1:0]      unit_bucket;

  logic               valid_we;
  logic [BW-1:0]      valid_waddr;
  logic [WAYS-1:0]    valid_wdata;
  logic [WAYS-1:0]    valid_row;
  logic               key_we;
  logic               value_we;
  logic [AW-1:0]      kv_waddr;
  logic [AW-1:0]      kv_raddr;
  logic [KEY_W-1:0]   key_rdata;
  logic [VALUE_W-1:0] value_rdata;

  // A count of zero acts as one bucket; counts above BUCKETS saturate.
  always_comb begin
    if (bucket_count_q == '0) begin
      active_count = DW'(1);
    end else if (32'(bucket_count_q) > 32'(BUCKETS)) begin
      active_count = DW'(BUCKETS);
    end else begin
      active_count = DW'(bucket_count_q);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign unit_start  = in_valid_i && in_ready_o;
  assign kv_raddr    = base_q + AW'(wc_q);

  hkv_hash_div #(
    .BUCKETS(BUCKETS)
  ) u_hash_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (unit_start),
    .key_i    (in_data_i.key),
    .divisor_i(active_count),
    .done_o   (unit_done),
    .bucket_o (unit_bucket)
  );

  // One row of valid marks per bucket; it is read at bucket_q all the time.
  hkv_ram #(
    .WIDTH(WAYS),
    .DEPTH(BUCKETS)
  ) u_valid_ram (
    .clk_i  (clk_i),
    .we_i   (valid_we),
    .waddr_i(valid_waddr),
    .wdata_i(valid_wdata),
    .raddr_i(bucket_q),
    .rdata_o(valid_row)
  );

  hkv_ram #(
    .WIDTH(KEY_W),
    .DEPTH(SLOTS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(kv_waddr),
    .wdata_i(req_q.key),
    .raddr_i(kv_raddr),
    .rdata_o(key_rdata)
  );

  hkv_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(SLOTS)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (value_we),
    .waddr_i(kv_waddr),
    .wdata_i(req_q.new_value),
    .raddr_i(kv_raddr),
    .rdata_o(value_rdata)
  );

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    bucket_d    = bucket_q;
    base_d      = base_q;
    clr_d       = clr_q;
    wc_d        = wc_q;
    pend_d      = pend_q;
    pw_d        = pw_q;
    hit_d       = hit_q;
    hit_way_d   = hit_way_q;
    hit_val_d   = hit_val_q;
    free_d      = free_q;
    free_way_d  = free_way_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    valid_we    = 1'b0;
    valid_waddr = bucket_q;
    valid_wdata = valid_row;
    key_we      = 1'b0;
    value_we    = 1'b0;
    kv_waddr    = base_q + AW'(hit_way_q);

    unique case (state_q)
      S_CLEAR: begin
        valid_we    = 1'b1;
        valid_waddr = clr_q;
        valid_wdata = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (unit_done) begin
          bucket_d = unit_bucket;
          base_d   = AW'(unit_bucket) * AW'(WAYS);
          wc_d     = '0;
          pend_d   = 1'b0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          state_d  = S_VRD;
        end
      end
      S_VRD: begin
        // The valid row of the new bucket arrives at the end of this cycle.
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // Reads are issued one way per cycle; the data of the way read in
        // the previous cycle is checked here.
        if (wc_q != CW'(WAYS)) begin
          wc_d   = wc_q + 1'b1;
          pend_d = 1'b1;
          pw_d   = wc_q[WW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (valid_row[pw_q]) begin
            if (!hit_q && key_rdata == req_q.key) begin
              hit_d     = 1'b1;
              hit_way_d = pw_q;
              hit_val_d = value_rdata;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_way_d = pw_q;
          end
        end
        if (wc_q == CW'(WAYS) && !pend_q) begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_data_d.status     = ST_MISS;
          out_data_d.read_value = '0;
          case (req_q.opcode)
            OP_INSERT: begin
              if (hit_q) begin
                value_we          = 1'b1;
                out_data_d.status = ST_OK;
              end else if (free_q) begin
                kv_waddr          = base_q + AW'(free_way_q);
                key_we            = 1'b1;
                value_we          = 1'b1;
                valid_we          = 1'b1;
                valid_wdata       = valid_row | (WAYS'(1) << free_way_q);
                out_data_d.status = ST_OK;
              end else begin
                out_data_d.status = ST_FULL;
              end
            end
            OP_DELETE: begin
              if (hit_q) begin
                valid_we          = 1'b1;
                valid_wdata       = valid_row & ~(WAYS'(1) << hit_way_q);
                out_data_d.status = ST_OK;
              end
            end
            OP_GET: begin
              if (hit_q) begin
                out_data_d.status     = ST_OK;
                out_data_d.read_value = hit_val_q;
              end
            end
            default: begin
              out_data_d.status = ST_MISS;
            end
          endcase
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_q          <= '0;
      bucket_count_q <= BUCKET_COUNT_RESET;
      out_valid_q    <= 1'b0;
      wc_q           <= '0;
      pend_q         <= 1'b0;
      hit_q          <= 1'b0;
      free_q         <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      wc_q        <= wc_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bucket_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    bucket_q   <= bucket_d;
    base_q     <= base_d;
    pw_q       <= pw_d;
    hit_way_q  <= hit_way_d;
    hit_val_q  <= hit_val_d;
    free_way_q <= free_way_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* hw/rtl/hkv_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module hkv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/hkv_hash_div.sv */
// Iterative unit that mixes a key and reduces it modulo the bucket count.
`timescale 1ns / 1ps

module hkv_hash_div #(
  parameter int unsigned BUCKETS = hkv_pkg::BUCKETS_DEFAULT,
  localparam int unsigned DW     = $clog2(BUCKETS + 1),
  localparam int unsigned BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [hkv_pkg::KEY_W-1:0] key_i,
  input  logic [DW-1:0]            divisor_i,
  output logic                     done_o,
  output logic [BW-1:0]            bucket_o
);

  import hkv_pkg::*;

  localparam int unsigned LAST_STEP = HASH_STEPS + KEY_W - 1;
  localparam int unsigned CNT_W     = $clog2(LAST_STEP + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_W-1:0] k_q, k_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    div_q, div_d;
  logic [DW:0]      rem_sh;

  // The first steps run the key mix in place; the rest are restoring division
  // steps that shift the mixed word out of k_q, one quotient bit at a time.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    k_d    = k_q;
    rem_d  = rem_q;
    div_d  = div_q;
    rem_sh = {rem_q, k_q[KEY_W-1]};
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      k_d    = key_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (cnt_q < CNT_W'(HASH_STEPS)) begin
        k_d = hkv_mix_step(k_q, cnt_q[STEP_W-1:0]);
      end else begin
        k_d = k_q << 1;
        if (rem_sh >= {1'b0, div_q}) begin
          rem_d = DW'(rem_sh - {1'b0, div_q});
        end else begin
          rem_d = rem_sh[DW-1:0];
        end
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(LAST_STEP)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q[BW-1:0];

endmodule

/* hw/rtl/hkv_checker.sv */
// Port-level assertions for the hashed key-value table and their binding.
`timescale 1ns / 1ps

module hkv_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input hkv_pkg::hkv_rsp_t out_data_o
);

  import hkv_pkg::*;

  // A stalled response must hold until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled response changed or dropped");

  // Only one request is in flight, so the block stops taking requests at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // Only a response with the OK status may carry a read value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.read_value == '0)
    else $error("value returned with a miss or full status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status == ST_OK || out_data_o.status == ST_MISS ||
                    out_data_o.status == ST_FULL)
    else $error("unknown response status");

endmodule

bind hashed_key_value_table hkv_checker u_hkv_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

/* test/tb_hashed_key_value_table.sv */
// Self-checking testbench for the hashed key-value table with a built-in predictor.
`timescale 1ns / 1ps

module tb_hashed_key_value_table;
  import hkv_pkg::*;

  localparam int unsigned BUCKETS   = BUCKETS_DEFAULT;
  localparam int unsigned WAYS      = WAYS_DEFAULT;
  localparam int unsigned SLOTS     = BUCKETS * WAYS;
  localparam int unsigned LATENCY   = WAYS + 43;
  localparam int unsigned STALL_MAX = 4000;
  localparam int unsigned POOL_MAX  = 40;

  // Opcode 3 has no meaning in the block and must answer as a miss.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic           is_cfg;
    logic [CFG_W-1:0] cfg_value;
    hkv_req_t       req;
    logic           given;
    hkv_rsp_t       rsp;
  } directed_row_t;

  typedef struct packed {
    logic [CFG_W-1:0] buckets;
    logic [7:0]       pool_n;
    logic [15:0]      items;
    logic [7:0]       send_idle;
    logic [7:0]       recv_idle;
  } random_phase_t;

  localparam int DIRECTED_ROWS = 27;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b0, 9'd0,   '{OP_GET,    32'h0000_0000, 32'h0000_0000}, 1'b1, '{ST_MISS, 32'h0}},
    '{1'b0, 9'd0,   '{OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1, '{ST_MISS, 32'h0}},
    '{1'b0, 9'd0,   '{OP_UNUSED, 32'h1234_5678, 32'hDEAD_BEEF}, 1'b1, '{ST_MISS, 32'h0}},
    '{1'b0, 9'd0,   '{OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_GET,    32'h0000_0000, 32'h0000_0000}, 1'b1,
      '{ST_OK, 32'hFFFF_FFFF}},
    '{1'b0, 9'd0,   '{OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_INSERT, 32'h0000_0000, 32'h5A5A_5A5A}, 1'b1, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_GET,    32'h0000_0000, 32'h0000_0000}, 1'b1,
      '{ST_OK, 32'h5A5A_5A5A}},
    '{1'b0, 9'd0,   '{OP_DELETE, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_GET,    32'h0000_0000, 32'h0000_0000}, 1'b1, '{ST_MISS, 32'h0}},
    '{1'b0, 9'd0,   '{OP_DELETE, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{ST_MISS, 32'h0}},
    '{1'b0, 9'd0,   '{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{ST_MISS, 32'h0}},
    // A single bucket: five distinct keys overflow its ways.
    '{1'b1, 9'd1,   '{OP_GET,    32'h0000_0000, 32'h0000_0000}, 1'b0, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_INSERT, 32'h1111_1111, 32'hA5A5_0001}, 1'b0, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_INSERT, 32'h2222_2222, 32'hA5A5_0002}, 1'b0, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_INSERT, 32'h3333_3333, 32'hA5A5_0003}, 1'b0, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_INSERT, 32'h4444_4444, 32'hA5A5_0004}, 1'b0, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_INSERT, 32'h5555_5555, 32'hA5A5_0005}, 1'b0, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_GET,    32'h3333_3333, 32'h0000_0000}, 1'b0, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_DELETE, 32'h2222_2222, 32'h0000_0000}, 1'b0, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_INSERT, 32'h5555_5555, 32'hA5A5_0006}, 1'b0, '{ST_OK,   32'h0}},
    // A zero count behaves as one bucket.
    '{1'b1, 9'd0,   '{OP_GET,    32'h0000_0000, 32'h0000_0000}, 1'b0, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_GET,    32'h1111_1111, 32'h0000_0000}, 1'b0, '{ST_OK,   32'h0}},
    // An oversized count saturates, so the entry stored at full size is found again.
    '{1'b1, 9'd511, '{OP_GET,    32'h0000_0000, 32'h0000_0000}, 1'b0, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_GET,    32'hFFFF_FFFF, 32'h0000_0000}, 1'b1, '{ST_OK,   32'h0}},
    '{1'b0, 9'd0,   '{OP_GET,    32'h1111_1111, 32'h0000_0000}, 1'b0, '{ST_OK,   32'h0}}
  };

  localparam int RANDOM_PHASES = 6;
  localparam random_phase_t PHASES [RANDOM_PHASES] = '{
    '{9'd1,   8'd8,  16'd120, 8'd25, 8'd45},
    '{9'd3,   8'd16, 16'd120, 8'd25, 8'd45},
    '{9'd256, 8'd24, 16'd120, 8'd45, 8'd25},
    '{9'd2,   8'd12, 16'd120, 8'd45, 8'd25},
    '{9'd200, 8'd40, 16'd120, 8'd0,  8'd0},
    '{9'd511, 8'd16, 16'd125, 8'd0,  8'd0}
  };

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  hkv_req_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  hkv_rsp_t         out_data_o;

  logic             mirror_valid [SLOTS];
  logic [KEY_W-1:0] mirror_key   [SLOTS];
  logic [VALUE_W-1:0] mirror_value [SLOTS];
  int unsigned      buckets_cfg;
  logic [KEY_W-1:0] key_pool [POOL_MAX];

  hkv_rsp_t         replies_due [$];
  int unsigned      mismatches   = 0;
  int unsigned      replies_seen = 0;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      quiet_cycles = 0;

  hashed_key_value_table #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [KEY_W-1:0] wang_mix(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] h;
    h = ~k + (k << 15);
    h = h ^ (h >> 12);
    h = h + (h << 2);
    h = h ^ (h >> 4);
    h = h + (h << 3) + (h << 11);
    h = h ^ (h >> 16);
    return h;
  endfunction

  // Applies one request to the mirrored entries and returns the reply it must give.
  function automatic hkv_rsp_t lookup_and_update(input hkv_req_t req);
    hkv_rsp_t    rsp;
    int unsigned used;
    int unsigned base;
    int          hit_way;
    int          free_way;
    used = (buckets_cfg == 0) ? 1 : ((buckets_cfg > BUCKETS) ? BUCKETS : buckets_cfg);
    base = (wang_mix(req.key) % used) * WAYS;
    hit_way  = -1;
    free_way = -1;
    rsp.status     = ST_MISS;
    rsp.read_value = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (mirror_valid[base + w]) begin
        if (hit_way < 0 && mirror_key[base + w] == req.key) hit_way = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    case (req.opcode)
      OP_INSERT: begin
        if (hit_way >= 0) begin
          mirror_value[base + hit_way] = req.new_value;
          rsp.status = ST_OK;
        end else if (free_way >= 0) begin
          mirror_valid[base + free_way] = 1'b1;
          mirror_key[base + free_way]   = req.key;
          mirror_value[base + free_way] = req.new_value;
          rsp.status = ST_OK;
        end else begin
          rsp.status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (hit_way >= 0) begin
          mirror_valid[base + hit_way] = 1'b0;
          rsp.status = ST_OK;
        end
      end
      OP_GET: begin
        if (hit_way >= 0) begin
          rsp.read_value = mirror_value[base + hit_way];
          rsp.status     = ST_OK;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // Presents one request and, once it transfers, queues the reply it must give.
  task automatic send_request(input hkv_req_t req, input logic use_given,
                              input hkv_rsp_t given);
    hkv_rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = lookup_and_update(req);
    replies_due.push_back(use_given ? given : predicted);
  endtask

  task automatic wait_for_replies();
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    buckets_cfg = value;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    hkv_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("reply %0d with no request outstanding (status %0d)",
                                  replies_seen, out_data_o.status));
      end else begin
        want = replies_due.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                    replies_seen, out_data_o.status, want.status));
        if (out_data_o.read_value !== want.read_value)
          report_mismatch($sformatf("reply %0d read_value %h, want %h",
                                    replies_seen, out_data_o.read_value, want.read_value));
      end
      replies_seen++;
    end
  end

  // Ends the run if no transfer happens on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    hkv_req_t req;
    int unsigned pick;
    buckets_cfg  = BUCKET_COUNT_RESET;
    for (int s = 0; s < SLOTS; s++) begin
      mirror_valid[s] = 1'b0;
      mirror_key[s]   = '0;
      mirror_value[s] = '0;
    end
    for (int p = 0; p < POOL_MAX; p++) key_pool[p] = $urandom;
    send_idle_pct = 25;
    recv_idle_pct = 45;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].is_cfg) begin
        wait_for_replies();
        write_bucket_count(DIRECTED[i].cfg_value);
      end else begin
        send_request(DIRECTED[i].req, DIRECTED[i].given, DIRECTED[i].rsp);
      end
    end

    // Keys mostly come from a small pool so that hits, overwrites and full buckets
    // are common; the rest are fresh keys that mostly miss.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_for_replies();
      write_bucket_count(PHASES[ph].buckets);
      send_idle_pct = PHASES[ph].send_idle;
      recv_idle_pct = PHASES[ph].recv_idle;
      for (int n = 0; n < PHASES[ph].items; n++) begin
        pick = $urandom_range(99);
        if (pick < 40)      req.opcode = OP_INSERT;
        else if (pick < 62) req.opcode = OP_DELETE;
        else if (pick < 95) req.opcode = OP_GET;
        else                req.opcode = OP_UNUSED;
        if ($urandom_range(9) == 0) req.key = $urandom;
        else req.key = key_pool[$urandom_range(PHASES[ph].pool_n - 1)];
        req.new_value = $urandom;
        send_request(req, 1'b0, '0);
      end
    end

    wait_for_replies();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
